// ===== rtl/hcp_pkg.sv =====
// Shared types and constants of the heap property check and post-order unit.
package hcp_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 6;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned OutDataW = 40;  // class + key, padded to whole bytes

  localparam logic [ClassW-1:0] HEAP_MAX  = 2'd0;
  localparam logic [ClassW-1:0] HEAP_MIN  = 2'd1;
  localparam logic [ClassW-1:0] HEAP_NONE = 2'd2;

  localparam logic KIND_CLASS = 1'b0;
  localparam logic KIND_KEY   = 1'b1;

  // Key store access from the sequencer.
  typedef struct packed {
    logic              we;
    logic [CountW-1:0] waddr;
    logic [KeyW-1:0]   wdata;
    logic              re;
    logic [CountW-1:0] raddr;
  } mem_req_t;

  // One result handed to the output register.
  typedef struct packed {
    logic              load;
    logic              kind;
    logic [ClassW-1:0] heap_class;
    logic [KeyW-1:0]   key;
    logic              last;
  } emit_t;

endpackage

// ===== rtl/hcp_key_store.sv =====
// Key store: one write port, one read port with registered read data.
module hcp_key_store #(
  parameter int unsigned Depth = 63
) (
  input  logic                      clk_i,
  input  hcp_pkg::mem_req_t         req_i,
  output logic [hcp_pkg::KeyW-1:0]  rdata_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [hcp_pkg::KeyW-1:0] mem_q [Depth];
  logic [hcp_pkg::KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hcp_seq.sv =====
// Sequencer: key loading with parent compare, then iterative post-order walk.
module hcp_seq #(
  parameter int unsigned MaxKeys = 63
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hcp_pkg::CountW-1:0]  key_count_i,
  input  logic                        in_valid_i,
  input  logic [hcp_pkg::KeyW-1:0]    in_key_i,
  output logic                        in_ready_o,
  output hcp_pkg::mem_req_t           mem_req_o,
  input  logic [hcp_pkg::KeyW-1:0]    rdata_i,
  input  logic                        slot_free_i,
  output hcp_pkg::emit_t              emit_o
);

  localparam int unsigned CW = hcp_pkg::CountW;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_CMP   = 6'b000010,
    S_CLASS = 6'b000100,
    S_DESC  = 6'b001000,
    S_FETCH = 6'b010000,
    S_EMIT  = 6'b100000
  } hcp_state_e;

  hcp_state_e state_q, state_d;
  logic [CW-1:0] load_pos_q, load_pos_d;
  logic [CW-1:0] cur_pos_q, cur_pos_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] node_q, node_d;
  logic          close_q, close_d;
  logic          max_ok_q, max_ok_d;
  logic          min_ok_q, min_ok_d;
  logic [hcp_pkg::KeyW-1:0] key_q, key_d;

  logic [CW-1:0] n_eff;
  logic          accept;
  logic          key_gt, key_lt;
  logic [CW:0]   node_dbl, node_inc;
  logic [hcp_pkg::ClassW-1:0] cls;

  always_comb begin
    if (key_count_i == '0) begin
      n_eff = CW'(1);
    end else if (key_count_i > CW'(MaxKeys)) begin
      n_eff = CW'(MaxKeys);
    end else begin
      n_eff = key_count_i;
    end
  end

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  // Shared compare unit: new key against its parent from the store.
  assign key_gt = $signed(key_q) > $signed(rdata_i);
  assign key_lt = $signed(key_q) < $signed(rdata_i);

  assign node_dbl = {node_q, 1'b0};
  assign node_inc = {1'b0, node_q} + (CW+1)'(1);

  always_comb begin
    if (max_ok_q) begin
      cls = hcp_pkg::HEAP_MAX;
    end else if (min_ok_q) begin
      cls = hcp_pkg::HEAP_MIN;
    end else begin
      cls = hcp_pkg::HEAP_NONE;
    end
  end

  always_comb begin
    state_d    = state_q;
    load_pos_d = load_pos_q;
    cur_pos_d  = cur_pos_q;
    n_d        = n_q;
    node_d     = node_q;
    close_d    = close_q;
    max_ok_d   = max_ok_q;
    min_ok_d   = min_ok_q;
    key_d      = key_q;
    mem_req_o  = '0;
    emit_o     = '0;

    case (state_q)
      S_LOAD: begin
        if (accept) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = load_pos_q;
          mem_req_o.wdata = in_key_i;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = (load_pos_q - CW'(1)) >> 1;
          key_d     = in_key_i;
          cur_pos_d = load_pos_q;
          close_d   = ({1'b0, load_pos_q} + (CW+1)'(1)) >= {1'b0, n_eff};
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        if (cur_pos_q != '0) begin
          if (key_gt) max_ok_d = 1'b0;
          if (key_lt) min_ok_d = 1'b0;
        end
        if (close_q) begin
          load_pos_d = '0;
          n_d        = cur_pos_q + CW'(1);
          state_d    = S_CLASS;
        end else begin
          load_pos_d = load_pos_q + CW'(1);
          state_d    = S_LOAD;
        end
      end
      S_CLASS: begin
        if (slot_free_i) begin
          emit_o.load       = 1'b1;
          emit_o.kind       = hcp_pkg::KIND_CLASS;
          emit_o.heap_class = cls;
          max_ok_d = 1'b1;
          min_ok_d = 1'b1;
          node_d   = CW'(1);
          state_d  = S_DESC;
        end
      end
      S_DESC: begin
        // one level of the leftmost descent per cycle
        if (node_dbl <= {1'b0, n_q}) begin
          node_d = node_dbl[CW-1:0];
        end else begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = node_q - CW'(1);
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free_i) begin
          emit_o.load = 1'b1;
          emit_o.kind = hcp_pkg::KIND_KEY;
          emit_o.key  = rdata_i;
          emit_o.last = (node_q == CW'(1));
          if (node_q == CW'(1)) begin
            state_d = S_LOAD;
          end else if (!node_q[0] && (node_inc <= {1'b0, n_q})) begin
            node_d  = node_inc[CW-1:0];
            state_d = S_DESC;
          end else begin
            node_d  = node_q >> 1;
            state_d = S_FETCH;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_pos_q <= '0;
      max_ok_q   <= 1'b1;
      min_ok_q   <= 1'b1;
    end else begin
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      max_ok_q   <= max_ok_d;
      min_ok_q   <= min_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    n_q       <= n_d;
    node_q    <= node_d;
    close_q   <= close_d;
    key_q     <= key_d;
  end

`ifndef ASSERT_OFF
  a_ready_only_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_LOAD))
    else $error("input ready outside load state");

  a_load_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_pos_q < CW'(MaxKeys))
    else $error("load position beyond store depth");

  a_flags_reset_after_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.load && emit_o.kind == hcp_pkg::KIND_CLASS) |=> (max_ok_q && min_ok_q))
    else $error("order flags not restored after class result");
`endif

endmodule

// ===== rtl/heap_check_postorder_unit.sv =====
// Top level of the heap property check with post-order readout.
// Keys of a set arrive in level order. Each key is accepted in the load state,
// then compared with its parent in the compare state through the key store's
// registered read port, so the input is not ready while a key is compared.
// After the closing key the unit sends one class transaction (max heap, else
// min heap, else not a heap). It then sends every key in post-order, with tlast
// on the final one. For each key the walk reads the store, then loads the
// output register; the descent state steps down each leftmost descent one
// level at a time, then ends it. The input is not ready during the walk.
// Output backpressure stalls the walk. The output register lets the next set
// start loading while the last key still waits to be taken.
module heap_check_postorder_unit #(
  parameter int unsigned MAX_KEYS = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           key_count_we_i,
  input  logic [hcp_pkg::CountW-1:0]     key_count_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [hcp_pkg::KeyW-1:0]       s_axis_tdata_i,   // [31:0] key_value
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [hcp_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [1:0] heap_class, [33:2] post_key
  output logic                           m_axis_tuser_o,   // [0] result_kind
  output logic                           m_axis_tlast_o    // last_of_run
);

  logic [hcp_pkg::CountW-1:0] key_count_q;
  hcp_pkg::mem_req_t          mem_req;
  hcp_pkg::emit_t             emit;
  logic [hcp_pkg::KeyW-1:0]   rdata;
  logic                       slot_free;

  logic                         out_valid_q;
  logic                         out_kind_q;
  logic [hcp_pkg::ClassW-1:0]   out_class_q;
  logic [hcp_pkg::KeyW-1:0]     out_key_q;
  logic                         out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= hcp_pkg::CountW'(1);
    end else if (key_count_we_i) begin
      key_count_q <= key_count_i;
    end
  end

  hcp_key_store #(
    .Depth (MAX_KEYS)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  hcp_seq #(
    .MaxKeys (MAX_KEYS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_count_i (key_count_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_key_i    (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  assign slot_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_kind_q  <= emit.kind;
      out_class_q <= emit.heap_class;
      out_key_q   <= emit.key;
      out_last_q  <= emit.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(hcp_pkg::OutDataW - hcp_pkg::KeyW - hcp_pkg::ClassW){1'b0}},
                            out_key_q, out_class_q};

`ifndef ASSERT_OFF
  a_class_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == hcp_pkg::KIND_CLASS) |->
      (out_class_q == hcp_pkg::HEAP_MAX || out_class_q == hcp_pkg::HEAP_MIN ||
       out_class_q == hcp_pkg::HEAP_NONE))
    else $error("class transaction with undefined class code");

  a_key_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == hcp_pkg::KIND_KEY) |->
      (out_class_q == hcp_pkg::HEAP_MAX))
    else $error("key transaction with nonzero class field");

  a_last_only_on_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == hcp_pkg::KIND_KEY))
    else $error("tlast on a class transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.load |-> slot_free)
    else $error("output register loaded while occupied");
`endif

endmodule
